/* design/byte_ring_fifo_with_admission_macros.svh */
// Assertion macros for the byte ring FIFO checker.
// Included by the checker file only; no other dependencies.
`ifndef BYTE_RING_FIFO_WITH_ADMISSION_MACROS_SVH
`define BYTE_RING_FIFO_WITH_ADMISSION_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define BRF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BRF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/brf_pkg.sv */
// Shared types and constants for the byte ring FIFO with admission.
// No dependencies; used by every module of the block except brf_ram.
`default_nettype none

package brf_pkg;

   localparam int MAX_DEPTH = 1024;
   localparam int MIN_SIZE  = 512;
   localparam int ADDR_W    = $clog2(MAX_DEPTH);
   localparam int CNT_W     = 11;
   localparam int BYTE_W    = 8;
   localparam int RDR_W     = 8;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_OPEN    = 2'd2,
      CMD_RELEASE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_BOTH  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK               = 3'd0,
      ST_EMPTY            = 3'd1,
      ST_FULL             = 3'd2,
      ST_WRITER_BUSY      = 3'd3,
      ST_TOO_MANY_READERS = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RING_SIZE   = 2'd0,
      CSR_MAX_READERS = 2'd1
   } csr_idx_type;

   typedef enum logic {
      S_IDLE      = 1'b0,
      S_READ_WAIT = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;     // take the current request beat
      logic load_mem;   // capture RAM read data into data_out
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pop_go;     // current request is a read that will pop a byte
   } dp_stat_type;

endpackage

`default_nettype wire

/* design/brf_if.sv */
// Channel interfaces for the byte ring FIFO: request and response.
// Plain valid/ready handshake; no package dependency.
`default_nettype none

interface brf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data_in;
   logic [1:0] access_mode;

   modport source (output valid, cmd, data_in, access_mode, input ready);
   modport sink   (input valid, cmd, data_in, access_mode, output ready);
endinterface

interface brf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_out;
   logic [2:0]  status;
   logic [10:0] used_count;
   logic [10:0] free_count;

   modport source (output valid, data_out, status, used_count, free_count, input ready);
   modport sink   (input valid, data_out, status, used_count, free_count, output ready);
endinterface

`default_nettype wire

/* design/byte_ring_fifo_with_admission.sv */
// Top level of the byte ring FIFO with reader/writer admission.
// Depends on brf_pkg, brf_if, brf_ctrl, brf_dp and brf_ram.
`default_nettype none

// One request beat in, one response beat out. Write, open, release and a
// refused read have their response registered on accept, so those beats
// can be accepted back to back while the response register drains. A read
// that pops a byte waits in S_READ_WAIT for the byte store, a single RAM
// with registered read data. The store needs no clearing pass after reset;
// only bytes written since the last emptying are ever read. Writing the
// ring size CSR (index 0) empties the store; max_readers is index 1.
// Write the CSRs only while no response is outstanding.
module byte_ring_fifo_with_admission (
   input  wire logic                          clock,
   input  wire logic                          reset,
   brf_req_if.sink                            req_ch,
   brf_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_we,
   input  wire logic [brf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [brf_pkg::CNT_W-1:0]     csr_wdata
);
   import brf_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   brf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .stat            (dp_stat),
      .req_cmd         (req_ch.cmd),
      .req_data_in     (req_ch.data_in),
      .req_access_mode (req_ch.access_mode),
      .rsp_data_out    (rsp_ch.data_out),
      .rsp_status      (rsp_ch.status),
      .rsp_used_count  (rsp_ch.used_count),
      .rsp_free_count  (rsp_ch.free_count),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

endmodule

`default_nettype wire

/* design/brf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* design/brf_ctrl.sv */
// Controller for the byte ring FIFO: request/response handshake sequencing.
// Depends on brf_pkg.
`default_nettype none

module brf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire brf_pkg::dp_stat_type  stat,
   output      brf_pkg::ctrl_cmd_type cmd
);
   import brf_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and response-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            // output slot free, or draining this cycle
            req_ready  = !rsp_valid_ff || rsp_ready;
            cmd.accept = req_valid && req_ready;
            if (cmd.accept) begin
               if (stat.pop_go) begin
                  state_in = S_READ_WAIT;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_READ_WAIT: begin
            // RAM data is ready; response slot is empty here
            cmd.load_mem = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* design/brf_dp.sv */
// Datapath for the byte ring FIFO: pointers, counts, admission, CSRs, response.
// Depends on brf_pkg and brf_ram.
`default_nettype none

module brf_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire brf_pkg::ctrl_cmd_type         cmd,
   output      brf_pkg::dp_stat_type          stat,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [brf_pkg::BYTE_W-1:0]    req_data_in,
   input  wire logic [1:0]                    req_access_mode,
   output      logic [brf_pkg::BYTE_W-1:0]    rsp_data_out,
   output      logic [2:0]                    rsp_status,
   output      logic [brf_pkg::CNT_W-1:0]     rsp_used_count,
   output      logic [brf_pkg::CNT_W-1:0]     rsp_free_count,
   input  wire logic                          csr_we,
   input  wire logic [brf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [brf_pkg::CNT_W-1:0]     csr_wdata
);
   import brf_pkg::*;

   // one step around the ring of active size
   function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p,
                                                 input logic [CNT_W-1:0]  size);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(p) + CNT_W'(1);
      return (nxt >= size) ? '0 : ADDR_W'(nxt);
   endfunction

   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [RDR_W-1:0]  readers_ff, readers_in;
   logic              writer_ff, writer_in;
   logic [CNT_W-1:0]  buf_size_ff;
   logic [RDR_W-1:0]  max_rdr_ff;

   logic [BYTE_W-1:0] dout_ff;
   status_type        status_ff, status_in;
   logic [CNT_W-1:0]  used_ff;
   logic [CNT_W-1:0]  free_ff;

   logic [CNT_W-1:0]  size_act;
   cmd_type           op;
   mode_type          mode;
   logic              want_w, want_r;
   logic              push, pop;
   logic [BYTE_W-1:0] ram_rdata;

   // clamp size register to the supported range
   always_comb begin
      if (buf_size_ff < CNT_W'(MIN_SIZE)) begin
         size_act = CNT_W'(MIN_SIZE);
      end else if (buf_size_ff > CNT_W'(MAX_DEPTH)) begin
         size_act = CNT_W'(MAX_DEPTH);
      end else begin
         size_act = buf_size_ff;
      end
   end

   assign op     = cmd_type'(req_cmd);
   assign mode   = mode_type'(req_access_mode);
   assign want_w = (mode == MODE_WRITE) || (mode == MODE_BOTH);
   assign want_r = (mode == MODE_READ)  || (mode == MODE_BOTH);

   // command decode and next state
   always_comb begin
      status_in  = ST_OK;
      push       = 1'b0;
      pop        = 1'b0;
      readers_in = readers_ff;
      writer_in  = writer_ff;
      case (op)
         CMD_WRITE: begin
            if (fill_ff >= size_act) begin
               status_in = ST_FULL;
            end else begin
               push = 1'b1;
            end
         end
         CMD_READ: begin
            if (fill_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               pop = 1'b1;
            end
         end
         CMD_OPEN: begin
            if (want_w && writer_ff) begin
               status_in = ST_WRITER_BUSY;
            end else if (want_r && (readers_ff >= max_rdr_ff)) begin
               status_in = ST_TOO_MANY_READERS;
            end else begin
               if (want_w) writer_in = 1'b1;
               if (want_r) readers_in = readers_ff + RDR_W'(1);
            end
         end
         CMD_RELEASE: begin
            if (want_w) writer_in = 1'b0;
            if (want_r && (readers_ff != '0)) readers_in = readers_ff - RDR_W'(1);
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign rd_ptr_in = pop  ? advance(rd_ptr_ff, size_act) : rd_ptr_ff;
   assign wr_ptr_in = push ? advance(wr_ptr_ff, size_act) : wr_ptr_ff;
   always_comb begin
      fill_in = fill_ff;
      if (push) fill_in = fill_ff + CNT_W'(1);
      if (pop)  fill_in = fill_ff - CNT_W'(1);
   end

   assign stat.pop_go = pop;

   // control state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         fill_ff     <= '0;
         readers_ff  <= '0;
         writer_ff   <= 1'b0;
         buf_size_ff <= CNT_W'(MAX_DEPTH);
         max_rdr_ff  <= RDR_W'(1);
      end else if (csr_we) begin
         // config writes must only arrive while idle; the block does not enforce it
         if (csr_idx_type'(csr_index) == CSR_RING_SIZE) begin
            buf_size_ff <= csr_wdata;
            rd_ptr_ff   <= '0;
            wr_ptr_ff   <= '0;
            fill_ff     <= '0;
         end else if (csr_idx_type'(csr_index) == CSR_MAX_READERS) begin
            max_rdr_ff <= csr_wdata[RDR_W-1:0];
         end
      end else if (cmd.accept) begin
         rd_ptr_ff  <= rd_ptr_in;
         wr_ptr_ff  <= wr_ptr_in;
         fill_ff    <= fill_in;
         readers_ff <= readers_in;
         writer_ff  <= writer_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dout_ff   <= '0;
         status_ff <= status_in;
         used_ff   <= fill_in;
         free_ff   <= size_act - fill_in;
      end else if (cmd.load_mem) begin
         dout_ff <= ram_rdata;
      end
   end

   brf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.accept && push),
      .waddr (wr_ptr_ff),
      .wdata (req_data_in),
      .re    (cmd.accept && pop),
      .raddr (rd_ptr_ff),
      .rdata (ram_rdata)
   );

   assign rsp_data_out   = dout_ff;
   assign rsp_status     = status_ff;
   assign rsp_used_count = used_ff;
   assign rsp_free_count = free_ff;

endmodule

`default_nettype wire

/* design/brf_checker.sv */
// Port-level checker for the byte ring FIFO, bound to the top level.
// Depends on brf_pkg and the assertion macro header.
`default_nettype none
`include "byte_ring_fifo_with_admission_macros.svh"

module brf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_data_out,
   input wire logic [2:0]  rsp_status,
   input wire logic [10:0] rsp_used_count,
   input wire logic [10:0] rsp_free_count
);
   import brf_pkg::*;

   logic [11:0] total;
   assign total = {1'b0, rsp_used_count} + {1'b0, rsp_free_count};

   // stalled response beat holds its valid, data and used count
   `BRF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_used_count), "response changed while stalled")

   // used plus free lies within the active size range 512 to 1024
   `BRF_ASSERT(a_size_sum, clock, reset, rsp_valid |-> (total >= 12'd512) && (total <= 12'd1024), "used plus free outside size range")

   // refused read reports an empty store and no byte
   `BRF_ASSERT(a_empty, clock, reset, rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_used_count == 11'd0) && (rsp_data_out == 8'd0), "empty status with data")

   // refused write reports a full store
   `BRF_ASSERT(a_full, clock, reset, rsp_valid && (rsp_status == ST_FULL) |-> (rsp_free_count == 11'd0), "full status with free space")

endmodule

bind byte_ring_fifo_with_admission brf_checker u_brf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_data_out   (rsp_ch.data_out),
   .rsp_status     (rsp_ch.status),
   .rsp_used_count (rsp_ch.used_count),
   .rsp_free_count (rsp_ch.free_count)
);

`default_nettype wire
